// ===== sv/assert_macros.svh =====
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Concurrent assertion that is switched off while reset is held.
`define APSP_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Concurrent assertion that is also checked during reset.
`define APSP_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== sv/apsp_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package apsp_pkg;

    localparam int OPC_W  = 2;
    localparam int NODE_W = 6;
    localparam int WIN_W  = 16;
    localparam int DIST_W = 24;
    localparam int CFG_W  = 7;

    localparam logic [CFG_W-1:0]  CFG_RESET = 7'd64;
    localparam logic [DIST_W-1:0] DIST_MAX  = '1;

    typedef enum logic [OPC_W-1:0] {
        OP_CLEAR    = 2'd0,
        OP_ADD_EDGE = 2'd1,
        OP_COMPUTE  = 2'd2,
        OP_QUERY    = 2'd3
    } t_opcode;

    typedef struct packed {
        t_opcode             opcode;
        logic [NODE_W-1:0]   src_node;
        logic [NODE_W-1:0]   dst_node;
        logic [WIN_W-1:0]    edge_weight;
    } t_item;

    typedef struct packed {
        logic [DIST_W-1:0]   path_length;
        logic                reachable;
        logic [NODE_W-1:0]   next_hop;
    } t_result;

    typedef enum logic [3:0] {
        ST_INIT,
        ST_IDLE,
        ST_CLEAR,
        ST_QUERY,
        ST_IK,
        ST_IKW,
        ST_J,
        ST_JEND,
        ST_RESULT
    } t_state;

endpackage

`default_nettype wire

// ===== sv/apsp_item_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface apsp_item_if import apsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [OPC_W-1:0]  opcode;
    logic [NODE_W-1:0] src_node;
    logic [NODE_W-1:0] dst_node;
    logic [WIN_W-1:0]  edge_weight;

    modport source (output valid, opcode, src_node, dst_node, edge_weight, input ready);
    modport sink   (input valid, opcode, src_node, dst_node, edge_weight, output ready);
endinterface

`default_nettype wire

// ===== sv/apsp_result_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface apsp_result_if import apsp_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DIST_W-1:0] path_length;
    logic              reachable;
    logic [NODE_W-1:0] next_hop;

    modport source (output valid, path_length, reachable, next_hop, input ready);
    modport sink   (input valid, path_length, reachable, next_hop, output ready);
endinterface

`default_nettype wire

// ===== sv/apsp_cfg_if.sv =====
`timescale 1ns / 1ps
`default_nettype none

interface apsp_cfg_if import apsp_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CFG_W-1:0] node_count;

    modport source (output valid, node_count, input ready);
    modport sink   (input valid, node_count, output ready);
endinterface

`default_nettype wire

// ===== sv/apsp_mem.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apsp_mem #(
    parameter int AW    = 12,
    parameter int WIDTH = 25
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr_a,
    input  wire logic [AW-1:0]    i_raddr_b,
    output logic      [WIDTH-1:0] o_rdata_a,
    output logic      [WIDTH-1:0] o_rdata_b
);

    localparam int DEPTH = 1 << AW;

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata_a;
    logic [WIDTH-1:0] r_rdata_b;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata_a <= r_mem[i_raddr_a];
        r_rdata_b <= r_mem[i_raddr_b];
    end

    assign o_rdata_a = r_rdata_a;
    assign o_rdata_b = r_rdata_b;

endmodule

`default_nettype wire

// ===== sv/apsp_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module apsp_ctrl import apsp_pkg::*; #(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 16,
    parameter int IDX_W       = 6,
    parameter int CNT_W       = 7
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic [CFG_W-1:0]     i_node_count,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_item                i_item,
    output logic                      o_res_valid,
    input  wire logic                 i_res_ready,
    output t_result                   o_res,
    // distance memory: {infinite mark, distance}
    output logic                      o_d_we,
    output logic [2*IDX_W-1:0]        o_d_waddr,
    output logic [DIST_W:0]           o_d_wdata,
    output logic [2*IDX_W-1:0]        o_d_raddr_a,
    output logic [2*IDX_W-1:0]        o_d_raddr_b,
    input  wire logic [DIST_W:0]      i_d_rdata_a,
    input  wire logic [DIST_W:0]      i_d_rdata_b,
    // next-hop memory
    output logic                      o_h_we,
    output logic [IDX_W-1:0]          o_h_wdata,
    input  wire logic [IDX_W-1:0]     i_h_rdata_a
);

    localparam int AW   = 2 * IDX_W;
    localparam int CW   = (CNT_W > CFG_W) ? CNT_W : CFG_W;
    localparam logic [WIN_W-1:0] W_MASK = WIN_W'((33'd1 << WEIGHT_BITS) - 33'd1);

    t_state             r_state, n_state;
    logic [AW-1:0]      r_addr, n_addr;
    logic [IDX_W-1:0]   r_k, n_k;
    logic [IDX_W-1:0]   r_i, n_i;
    logic [IDX_W-1:0]   r_j, n_j;
    logic [CNT_W-1:0]   r_n, n_n;
    logic               r_pv, n_pv;
    logic [IDX_W-1:0]   r_pj, n_pj;
    logic [DIST_W-1:0]  r_dik, n_dik;
    logic [IDX_W-1:0]   r_hik, n_hik;
    logic               r_qok, n_qok;
    t_result            r_res, n_res;

    logic [CW-1:0]      nc_ext;
    logic [CW-1:0]      n_eff_w;
    logic [CNT_W-1:0]   n_eff;
    logic               in_range;
    logic [AW-1:0]      acc_addr;
    logic [DIST_W:0]    sum;
    logic [DIST_W-1:0]  sat;
    logic               relax_upd;
    logic               i_last;
    logic               k_last;
    logic               j_last;
    logic [IDX_W-1:0]   sw_row;
    logic [IDX_W-1:0]   sw_col;

    assign nc_ext   = CW'(i_node_count);
    assign n_eff_w  = (nc_ext > CW'(MAX_NODES)) ? CW'(MAX_NODES) : nc_ext;
    assign n_eff    = CNT_W'(n_eff_w);
    assign in_range = (CW'(i_item.src_node) < n_eff_w) && (CW'(i_item.dst_node) < n_eff_w);
    assign acc_addr = {IDX_W'(i_item.src_node), IDX_W'(i_item.dst_node)};

    // Relaxation of entry (i, j) through k; read data of port A is (k, j), port B is (i, j).
    assign sum       = {1'b0, r_dik} + {1'b0, i_d_rdata_a[DIST_W-1:0]};
    assign sat       = sum[DIST_W] ? DIST_MAX : sum[DIST_W-1:0];
    assign relax_upd = r_pv && !i_d_rdata_a[DIST_W]
                       && (i_d_rdata_b[DIST_W] || (sat < i_d_rdata_b[DIST_W-1:0]));

    assign i_last = (CNT_W'(r_i) == r_n - CNT_W'(1));
    assign k_last = (CNT_W'(r_k) == r_n - CNT_W'(1));
    assign j_last = (CNT_W'(r_j) == r_n - CNT_W'(1));

    assign sw_row = r_addr[AW-1:IDX_W];
    assign sw_col = r_addr[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_INIT;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_addr <= '0;
            r_pv   <= 1'b0;
        end else begin
            r_addr <= n_addr;
            r_pv   <= n_pv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_k   <= n_k;
        r_i   <= n_i;
        r_j   <= n_j;
        r_n   <= n_n;
        r_pj  <= n_pj;
        r_dik <= n_dik;
        r_hik <= n_hik;
        r_qok <= n_qok;
        r_res <= n_res;
    end

    always_comb begin
        n_state = r_state;
        n_addr  = r_addr;
        n_k     = r_k;
        n_i     = r_i;
        n_j     = r_j;
        n_n     = r_n;
        n_pv    = 1'b0;
        n_pj    = r_j;
        n_dik   = r_dik;
        n_hik   = r_hik;
        n_qok   = r_qok;
        n_res   = r_res;

        o_in_ready  = 1'b0;
        o_res_valid = 1'b0;

        o_d_we      = relax_upd;
        o_d_waddr   = {r_i, r_pj};
        o_d_wdata   = {1'b0, sat};
        o_h_we      = relax_upd;
        o_h_wdata   = r_hik;
        o_d_raddr_a = {r_i, r_k};
        o_d_raddr_b = {r_i, r_j};

        case (r_state)
            ST_INIT, ST_CLEAR: begin
                o_d_we    = 1'b1;
                o_d_waddr = r_addr;
                o_d_wdata = {(sw_row != sw_col), {DIST_W{1'b0}}};
                o_h_we    = 1'b1;
                o_h_wdata = sw_col;
                n_addr    = r_addr + AW'(1);
                if (r_addr == '1) begin
                    n_state = (r_state == ST_INIT) ? ST_IDLE : ST_RESULT;
                end
            end
            ST_IDLE: begin
                o_in_ready  = 1'b1;
                o_d_raddr_a = acc_addr;
                if (i_in_valid) begin
                    n_res = '0;
                    case (i_item.opcode)
                        OP_CLEAR: begin
                            n_addr  = '0;
                            n_state = ST_CLEAR;
                        end
                        OP_ADD_EDGE: begin
                            o_d_we    = in_range;
                            o_d_waddr = acc_addr;
                            o_d_wdata = {1'b0, DIST_W'(i_item.edge_weight & W_MASK)};
                            n_state   = ST_RESULT;
                        end
                        OP_COMPUTE: begin
                            n_k = '0;
                            n_i = '0;
                            n_n = n_eff;
                            n_state = (n_eff == '0) ? ST_RESULT : ST_IK;
                        end
                        OP_QUERY: begin
                            n_qok   = in_range;
                            n_state = ST_QUERY;
                        end
                        default: begin
                            n_state = ST_RESULT;
                        end
                    endcase
                end
            end
            ST_QUERY: begin
                n_res.reachable   = r_qok && !i_d_rdata_a[DIST_W];
                n_res.path_length = (r_qok && !i_d_rdata_a[DIST_W])
                                    ? i_d_rdata_a[DIST_W-1:0] : '0;
                n_res.next_hop    = r_qok ? NODE_W'(i_h_rdata_a) : '0;
                n_state           = ST_RESULT;
            end
            ST_IK: begin
                o_d_raddr_a = {r_i, r_k};
                n_state     = ST_IKW;
            end
            ST_IKW: begin
                n_dik = i_d_rdata_a[DIST_W-1:0];
                n_hik = i_h_rdata_a;
                if (!i_d_rdata_a[DIST_W]) begin
                    n_j     = '0;
                    n_state = ST_J;
                end else if (i_last) begin
                    n_i = '0;
                    if (k_last) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        n_state = ST_IK;
                    end
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = ST_IK;
                end
            end
            ST_J: begin
                o_d_raddr_a = {r_k, r_j};
                o_d_raddr_b = {r_i, r_j};
                n_pv        = 1'b1;
                n_pj        = r_j;
                if (j_last) begin
                    n_state = ST_JEND;
                end else begin
                    n_j = r_j + IDX_W'(1);
                end
            end
            ST_JEND: begin
                // The last write of the row lands here, before the next row is read.
                if (i_last) begin
                    n_i = '0;
                    if (k_last) begin
                        n_state = ST_RESULT;
                    end else begin
                        n_k     = r_k + IDX_W'(1);
                        n_state = ST_IK;
                    end
                end else begin
                    n_i     = r_i + IDX_W'(1);
                    n_state = ST_IK;
                end
            end
            ST_RESULT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    assign o_res = r_res;

endmodule

`default_nettype wire

// ===== sv/all_pairs_shortest_path.sv =====
// Channel   Dir  Payload                                   Request accepted when
// i_cfg     in   node_count                                valid && ready (ready always high)
// i_item    in   opcode, src_node, dst_node, edge_weight   valid && ready
// o_result  out  path_length, reachable, next_hop          valid && ready
//
// One request at a time. Add edge writes in the idle state and goes to the result stage; query passes the query state.
// Clear sweeps the whole table, one entry per cycle.
// Compute walks k and i; each row reads the (i,k) distance and, where it is finite,
// relaxes every j of the row through the memory write port.
// After reset the same sweep runs with i_item.ready low.
// A finished result waits in the output register while the next request is taken.
`timescale 1ns / 1ps
`default_nettype none

module all_pairs_shortest_path import apsp_pkg::*; #(
    parameter int MAX_NODES   = 64,
    parameter int WEIGHT_BITS = 16
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    apsp_cfg_if.sink       i_cfg,
    apsp_item_if.sink      i_item,
    apsp_result_if.source  o_result
);

    localparam int IDX_W = $clog2(MAX_NODES);
    localparam int CNT_W = $clog2(MAX_NODES + 1);
    localparam int AW    = 2 * IDX_W;

    logic [CFG_W-1:0]   r_node_count;
    logic               r_out_valid;
    t_result            r_out;

    t_item              item;
    logic               in_ready;
    logic               res_valid;
    logic               slot_free;
    t_result            res;

    logic               d_we;
    logic [AW-1:0]      d_waddr;
    logic [DIST_W:0]    d_wdata;
    logic [AW-1:0]      d_raddr_a;
    logic [AW-1:0]      d_raddr_b;
    logic [DIST_W:0]    d_rdata_a;
    logic [DIST_W:0]    d_rdata_b;
    logic               h_we;
    logic [IDX_W-1:0]   h_wdata;
    logic [IDX_W-1:0]   h_rdata_a;

    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CFG_RESET;
        end else if (i_cfg.valid) begin
            r_node_count <= i_cfg.node_count;
        end
    end

    assign item.opcode      = t_opcode'(i_item.opcode);
    assign item.src_node    = i_item.src_node;
    assign item.dst_node    = i_item.dst_node;
    assign item.edge_weight = i_item.edge_weight;
    assign i_item.ready     = in_ready;

    apsp_ctrl #(
        .MAX_NODES   (MAX_NODES),
        .WEIGHT_BITS (WEIGHT_BITS),
        .IDX_W       (IDX_W),
        .CNT_W       (CNT_W)
    ) u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_node_count (r_node_count),
        .i_in_valid   (i_item.valid),
        .o_in_ready   (in_ready),
        .i_item       (item),
        .o_res_valid  (res_valid),
        .i_res_ready  (slot_free),
        .o_res        (res),
        .o_d_we       (d_we),
        .o_d_waddr    (d_waddr),
        .o_d_wdata    (d_wdata),
        .o_d_raddr_a  (d_raddr_a),
        .o_d_raddr_b  (d_raddr_b),
        .i_d_rdata_a  (d_rdata_a),
        .i_d_rdata_b  (d_rdata_b),
        .o_h_we       (h_we),
        .o_h_wdata    (h_wdata),
        .i_h_rdata_a  (h_rdata_a)
    );

    apsp_mem #(
        .AW    (AW),
        .WIDTH (DIST_W + 1)
    ) u_dist_mem (
        .i_clk     (i_clk),
        .i_we      (d_we),
        .i_waddr   (d_waddr),
        .i_wdata   (d_wdata),
        .i_raddr_a (d_raddr_a),
        .i_raddr_b (d_raddr_b),
        .o_rdata_a (d_rdata_a),
        .o_rdata_b (d_rdata_b)
    );

    // Next-hop writes share the distance write address; only port A is read.
    apsp_mem #(
        .AW    (AW),
        .WIDTH (IDX_W)
    ) u_hop_mem (
        .i_clk     (i_clk),
        .i_we      (h_we),
        .i_waddr   (d_waddr),
        .i_wdata   (h_wdata),
        .i_raddr_a (d_raddr_a),
        .i_raddr_b (d_raddr_b),
        .o_rdata_a (h_rdata_a),
        .o_rdata_b ()
    );

    assign slot_free = !r_out_valid || o_result.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (slot_free) begin
            r_out_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (slot_free && res_valid) begin
            r_out <= res;
        end
    end

    assign o_result.valid       = r_out_valid;
    assign o_result.path_length = r_out.path_length;
    assign o_result.reachable   = r_out.reachable;
    assign o_result.next_hop    = r_out.next_hop;

endmodule

`default_nettype wire

// ===== sv/apsp_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

`include "assert_macros.svh"

module apsp_checker import apsp_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_in_valid,
    input wire logic              i_in_ready,
    input wire logic              i_out_valid,
    input wire logic              i_out_ready,
    input wire logic [DIST_W-1:0] i_path_length,
    input wire logic              i_reachable
);

    // The table is swept after reset before any request is taken.
    `APSP_ASSERT_ALWAYS(a_init_blocks, i_clk, !i_rst_n |=> !i_in_ready, "ready during reset sweep")

    // One request is worked on at a time.
    `APSP_ASSERT(a_one_at_a_time, i_clk, i_rst_n, (i_in_valid && i_in_ready) |=> !i_in_ready, "request taken twice in a row")

    // A result with no path reports zero length.
    `APSP_ASSERT(a_unreach_zero, i_clk, i_rst_n, (i_out_valid && !i_reachable) |-> (i_path_length == '0), "unreachable result with nonzero length")

    `APSP_ASSERT(a_out_hold, i_clk, i_rst_n, (i_out_valid && !i_out_ready) |=> i_out_valid, "result dropped while stalled")

endmodule

bind all_pairs_shortest_path apsp_checker u_apsp_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_in_valid    (i_item.valid),
    .i_in_ready    (i_item.ready),
    .i_out_valid   (o_result.valid),
    .i_out_ready   (o_result.ready),
    .i_path_length (o_result.path_length),
    .i_reachable   (o_result.reachable)
);

`default_nettype wire
